// ----- rtl/core/wjs_pkg.sv -----
// Shared types and constants of the weighted Jaccard sparse unit.
// No dependencies; every other file but wjs_ram imports this package.
package wjs_pkg;

    localparam int MAX_ENTRIES   = 256;
    localparam int KEY_BITS      = 32;
    localparam int WEIGHT_BITS   = 16;
    localparam int FRACTION_BITS = 16;

    localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int ENTRY_BITS  = KEY_BITS + WEIGHT_BITS;
    localparam int TOTAL_BITS  = 32;
    localparam int DEN_BITS    = TOTAL_BITS + 1;
    localparam int REM_BITS    = TOTAL_BITS + 2;
    localparam int COMMON_BITS = 24;
    localparam int UNION_BITS  = 25;
    localparam int SIM_BITS    = FRACTION_BITS + 1;
    localparam int ITER_BITS   = $clog2(FRACTION_BITS + 1);

    localparam logic [COMMON_BITS-1:0] COMMON_MAX = '1;
    localparam logic [UNION_BITS-1:0]  UNION_MAX  = '1;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_ORDER    = 2'd2
    } t_err_code;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CMP,
        S_SUM,
        S_UNION,
        S_CLAMP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_adv;
        logic walk_match;
        logic sum;
        logic union_calc;
        logic clamp;
        logic div_step;
        logic load_out;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic in_order;
        logic item_merge;
        logic item_last;
        logic held_last;
        logic pos_valid;
        logic key_less;
        logic key_equal;
        logic den_zero;
    } t_dp_status;

endpackage

// ----- rtl/core/wjs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/wjs_datapath.sv -----
// Datapath: entry store, merge walk, totals, union prep and restoring divider.
// Depends on wjs_pkg and wjs_ram.
module wjs_datapath import wjs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_ctrl,
    input  logic                   i_cmd,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_end_of_vector,
    output t_dp_status             o_status,
    output logic [COMMON_BITS-1:0] o_common_weight_sum,
    output logic [UNION_BITS-1:0]  o_union_weight_sum,
    output logic [SIM_BITS-1:0]    o_similarity,
    output logic                   o_undefined_ratio,
    output logic [1:0]             o_error_code
);

    function automatic logic [TOTAL_BITS-1:0] sat_add(
        input logic [TOTAL_BITS-1:0]  a,
        input logic [WEIGHT_BITS-1:0] b
    );
        logic [DEN_BITS-1:0] s;
        s = DEN_BITS'(a) + DEN_BITS'(b);
        return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
    endfunction

    // control state
    logic [COUNT_BITS-1:0]  r_count, n_count;
    logic [COUNT_BITS-1:0]  r_pos, n_pos;
    logic [TOTAL_BITS-1:0]  r_first, n_first;
    logic [TOTAL_BITS-1:0]  r_second, n_second;
    logic [TOTAL_BITS-1:0]  r_min, n_min;
    logic [KEY_BITS-1:0]    r_prev, n_prev;
    logic                   r_seen, n_seen;
    t_err_code              r_err, n_err;

    // payload
    logic [KEY_BITS-1:0]    r_key;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   r_last;
    logic [DEN_BITS-1:0]    r_sum;
    logic [DEN_BITS-1:0]    r_den;
    logic [TOTAL_BITS-1:0]  r_common;
    logic [REM_BITS-1:0]    r_rem;
    logic [SIM_BITS-1:0]    r_quo;
    logic [COMMON_BITS-1:0] r_out_common;
    logic [UNION_BITS-1:0]  r_out_union;
    logic [SIM_BITS-1:0]    r_out_sim;
    logic                   r_out_undef;
    logic [1:0]             r_out_err;

    logic                   in_order;
    logic                   store_free;
    logic                   store_we;
    logic [ENTRY_BITS-1:0]  rdata;
    logic [KEY_BITS-1:0]    s_key;
    logic [WEIGHT_BITS-1:0] s_weight;
    logic [WEIGHT_BITS-1:0] min_w;
    logic                   div_ge;
    logic [REM_BITS-1:0]    div_diff;

    assign in_order   = !r_seen || (i_key > r_prev);
    assign store_free = r_count < COUNT_BITS'(MAX_ENTRIES);
    assign store_we   = i_ctrl.accept && in_order && !i_cmd && store_free;

    wjs_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[ADDR_BITS-1:0]),
        .i_wdata ({i_key, i_weight}),
        .i_raddr (n_pos[ADDR_BITS-1:0]),
        .o_rdata (rdata)
    );

    assign s_key    = rdata[ENTRY_BITS-1:WEIGHT_BITS];
    assign s_weight = rdata[WEIGHT_BITS-1:0];
    assign min_w    = (s_weight < r_weight) ? s_weight : r_weight;

    assign div_ge   = r_rem >= REM_BITS'(r_den);
    assign div_diff = div_ge ? (r_rem - REM_BITS'(r_den)) : r_rem;

    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_first  = r_first;
        n_second = r_second;
        n_min    = r_min;
        n_prev   = r_prev;
        n_seen   = r_seen;
        n_err    = r_err;
        if (i_ctrl.accept) begin
            if (!in_order) begin
                if (r_err == ERR_NONE) begin
                    n_err = ERR_ORDER;
                end
            end else begin
                n_prev = i_key;
                n_seen = 1'b1;
                if (!i_cmd) begin
                    if (store_free) begin
                        n_count = r_count + COUNT_BITS'(1);
                        n_first = sat_add(r_first, i_weight);
                    end else if (r_err == ERR_NONE) begin
                        n_err = ERR_OVERFLOW;
                    end
                end else begin
                    n_second = sat_add(r_second, i_weight);
                end
            end
            // end of first vector restarts the order check
            if (i_end_of_vector && !i_cmd) begin
                n_seen = 1'b0;
                n_prev = '0;
            end
        end
        if (i_ctrl.walk_adv || i_ctrl.walk_match) begin
            n_pos = r_pos + COUNT_BITS'(1);
        end
        if (i_ctrl.walk_match) begin
            n_min = sat_add(r_min, min_w);
        end
        if (i_ctrl.clear) begin
            n_count  = '0;
            n_pos    = '0;
            n_first  = '0;
            n_second = '0;
            n_min    = '0;
            n_prev   = '0;
            n_seen   = 1'b0;
            n_err    = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pos    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_min    <= '0;
            r_prev   <= '0;
            r_seen   <= 1'b0;
            r_err    <= ERR_NONE;
        end else begin
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_first  <= n_first;
            r_second <= n_second;
            r_min    <= n_min;
            r_prev   <= n_prev;
            r_seen   <= n_seen;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_key    <= i_key;
            r_weight <= i_weight;
            r_last   <= i_end_of_vector;
        end
        if (i_ctrl.sum) begin
            r_sum <= DEN_BITS'(r_first) + DEN_BITS'(r_second);
        end
        if (i_ctrl.union_calc) begin
            r_den <= (r_sum >= DEN_BITS'(r_min)) ? (r_sum - DEN_BITS'(r_min)) : '0;
        end
        if (i_ctrl.clamp) begin
            if (DEN_BITS'(r_min) > r_den) begin
                r_common <= r_den[TOTAL_BITS-1:0];
                r_rem    <= REM_BITS'(r_den);
            end else begin
                r_common <= r_min;
                r_rem    <= REM_BITS'(r_min);
            end
            r_quo <= '0;
        end
        if (i_ctrl.div_step) begin
            r_rem <= {div_diff[REM_BITS-2:0], 1'b0};
            r_quo <= {r_quo[SIM_BITS-2:0], div_ge};
        end
        if (i_ctrl.load_out) begin
            r_out_common <= (r_common > TOTAL_BITS'(COMMON_MAX)) ?
                            COMMON_MAX : r_common[COMMON_BITS-1:0];
            r_out_union  <= (r_den > DEN_BITS'(UNION_MAX)) ?
                            UNION_MAX : r_den[UNION_BITS-1:0];
            r_out_sim    <= (r_den == '0) ? '0 : r_quo;
            r_out_undef  <= (r_den == '0);
            r_out_err    <= r_err;
        end
    end

    always_comb begin
        o_status.in_order   = in_order;
        o_status.item_merge = i_cmd;
        o_status.item_last  = i_end_of_vector;
        o_status.held_last  = r_last;
        o_status.pos_valid  = r_pos < r_count;
        o_status.key_less   = s_key < r_key;
        o_status.key_equal  = s_key == r_key;
        o_status.den_zero   = r_den == '0;
    end

    assign o_common_weight_sum = r_out_common;
    assign o_union_weight_sum  = r_out_union;
    assign o_similarity        = r_out_sim;
    assign o_undefined_ratio   = r_out_undef;
    assign o_error_code        = r_out_err;

endmodule

// ----- rtl/core/wjs_controller.sv -----
// Controller: sequences accept, merge walk, union prep, divide and result load.
// Depends on wjs_pkg.
module wjs_controller import wjs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_ctrl,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_state               r_state, n_state;
    logic [ITER_BITS-1:0] r_iter, n_iter;
    logic                 r_out_valid, n_out_valid;
    logic                 div_last;
    logic                 out_free;

    assign div_last = r_iter == ITER_BITS'(FRACTION_BITS);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_status.item_merge && i_status.in_order) begin
                        n_state = S_FETCH;
                    end else if (i_status.item_merge && i_status.item_last) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FETCH: n_state = S_CMP;
            S_CMP: begin
                priority if (i_status.pos_valid && i_status.key_less) begin
                    n_state = S_CMP;
                end else if (i_status.held_last) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SUM:   n_state = S_UNION;
            S_UNION: n_state = S_CLAMP;
            S_CLAMP: n_state = i_status.den_zero ? S_DONE : S_DIV;
            S_DIV:   n_state = div_last ? S_DONE : S_DIV;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctrl.accept = i_in_valid;
            end
            S_CMP: begin
                o_ctrl.walk_adv   = i_status.pos_valid && i_status.key_less;
                o_ctrl.walk_match = i_status.pos_valid && !i_status.key_less &&
                                    i_status.key_equal;
            end
            S_SUM:   o_ctrl.sum        = 1'b1;
            S_UNION: o_ctrl.union_calc = 1'b1;
            S_CLAMP: o_ctrl.clamp      = 1'b1;
            S_DIV:   o_ctrl.div_step   = 1'b1;
            S_DONE: begin
                o_ctrl.load_out = out_free;
                o_ctrl.clear    = out_free;
            end
            default: o_ctrl = '0;
        endcase
    end

    always_comb begin
        n_iter = r_iter;
        if (o_ctrl.clamp) begin
            n_iter = '0;
        end else if (o_ctrl.div_step) begin
            n_iter = r_iter + ITER_BITS'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/weighted_jaccard_sparse_unit.sv -----
// Weighted Jaccard similarity of two sparse vectors: one entry per transfer in,
// one result transfer out after the second vector's last entry.
// Depends on wjs_pkg, wjs_controller, wjs_datapath (and wjs_ram through it).
//
// A user sends the first vector's entries (cmd 0, ascending keys, end_of_vector
// on the last one) into a 256-entry store, then the second vector's entries
// (cmd 1) which are merge-walked against the store. The unit takes one entry at a
// time: a store entry is accepted and stored; a merge entry is accepted, read
// through the store's registered read port in a fetch step, then compared once
// per walk step, passing over smaller stored keys; an out-of-order entry is
// dropped. After the walk of the last merge entry (at once when that entry is
// out of order) the result follows: sum, union, clamp, then a restoring divider
// producing one quotient bit per cycle for FRACTION_BITS+1 bits (skipped when
// the union is zero), then the load into the output register; an untaken
// earlier result adds its own wait. The result register lets new entries be
// accepted while a result waits; a second result waits behind an untaken one.
// Out-of-order keys are dropped and flagged (error 2), entries beyond the store
// are dropped and flagged (error 1); the first error recorded wins. Loading a
// result into the output register clears the store, totals, order check and
// error state for the next pair.
module weighted_jaccard_sparse_unit import wjs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // entry channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_cmd,
    input  logic [KEY_BITS-1:0]    i_key,
    input  logic [WEIGHT_BITS-1:0] i_weight,
    input  logic                   i_end_of_vector,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COMMON_BITS-1:0] o_common_weight_sum,
    output logic [UNION_BITS-1:0]  o_union_weight_sum,
    output logic [SIM_BITS-1:0]    o_similarity,
    output logic                   o_undefined_ratio,
    output logic [1:0]             o_error_code
);

    t_dp_cmd    ctrl;
    t_dp_status status;

    // sequencing: one entry in flight, walk loop, divider iterations
    wjs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_ctrl      (ctrl),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // store, totals, divider and the result register
    wjs_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .i_cmd               (i_cmd),
        .i_key               (i_key),
        .i_weight            (i_weight),
        .i_end_of_vector     (i_end_of_vector),
        .o_status            (status),
        .o_common_weight_sum (o_common_weight_sum),
        .o_union_weight_sum  (o_union_weight_sum),
        .o_similarity        (o_similarity),
        .o_undefined_ratio   (o_undefined_ratio),
        .o_error_code        (o_error_code)
    );

endmodule

// ----- rtl/core/wjs_checker.sv -----
// Port-level checks of the weighted Jaccard sparse unit, bound to the top level.
// Depends on wjs_pkg and weighted_jaccard_sparse_unit.
module wjs_checker import wjs_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [COMMON_BITS-1:0] o_common_weight_sum,
    input logic [UNION_BITS-1:0]  o_union_weight_sum,
    input logic [SIM_BITS-1:0]    o_similarity,
    input logic                   o_undefined_ratio,
    input logic [1:0]             o_error_code
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_similarity) &&
        $stable(o_common_weight_sum) && $stable(o_union_weight_sum))
        else $error("result changed while stalled");

    // zero union: ratio, common sum and union sum all read zero
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_undefined_ratio |->
        o_similarity == '0 && o_common_weight_sum == '0 && o_union_weight_sum == '0)
        else $error("undefined ratio with nonzero fields");

    // ratio never above one
    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_similarity <= {1'b1, {FRACTION_BITS{1'b0}}})
        else $error("similarity above one");

    // common part never exceeds the union
    a_common_le_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> UNION_BITS'(o_common_weight_sum) <= o_union_weight_sum)
        else $error("common sum above union sum");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_error_code <= ERR_ORDER)
        else $error("unused error code");

endmodule

bind weighted_jaccard_sparse_unit wjs_checker u_wjs_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for weighted_jaccard_sparse_unit: random valid/ready traffic on both
// channels, a transaction-level predictor of the merge walk, and a field-by-field result check.
// Depends on wjs_pkg and the unit's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wjs_pkg::*;

    // Vector select codes on i_cmd
    localparam bit CMD_STORE = 1'b0;
    localparam bit CMD_MERGE = 1'b1;

    localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;  // cycles without any transfer before giving up
    localparam int RANDOM_ITEMS = 200;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic                   cmd;
        logic [KEY_BITS-1:0]    key;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   eov;
    } t_entry;

    typedef struct packed {
        logic [COMMON_BITS-1:0] common_sum;
        logic [UNION_BITS-1:0]  union_sum;
        logic [SIM_BITS-1:0]    ratio;
        logic                   undefined;
        t_err_code              err;
    } t_result;

    // DUT connections; the inputs driven here are known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_cmd = 1'b0;
    logic [KEY_BITS-1:0]    i_key = '0;
    logic [WEIGHT_BITS-1:0] i_weight = '0;
    logic                   i_end_of_vector = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [COMMON_BITS-1:0] o_common_weight_sum;
    logic [UNION_BITS-1:0]  o_union_weight_sum;
    logic [SIM_BITS-1:0]    o_similarity;
    logic                   o_undefined_ratio;
    logic [1:0]             o_error_code;

    weighted_jaccard_sparse_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_key               (i_key),
        .i_weight            (i_weight),
        .i_end_of_vector     (i_end_of_vector),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_common_weight_sum (o_common_weight_sum),
        .o_union_weight_sum  (o_union_weight_sum),
        .o_similarity        (o_similarity),
        .o_undefined_ratio   (o_undefined_ratio),
        .o_error_code        (o_error_code)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Traffic shaping knobs, written by the stimulus process on the falling edge
    int unsigned in_idle_pct  = 38;
    int unsigned out_idle_pct = 38;
    int unsigned hold_req     = 0;
    int unsigned hold_taken   = 0;
    int unsigned hold_left    = 0;

    t_entry  pending_entries[$];   // entries not yet offered to the unit
    t_result expected_results[$];  // predicted results awaiting their transfer
    int unsigned queued_items = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    //------------------------------------------------------------------
    // Predictor state: the store, the walk and the running sums
    //------------------------------------------------------------------
    logic [KEY_BITS-1:0]    stored_key [MAX_ENTRIES];
    logic [WEIGHT_BITS-1:0] stored_wt  [MAX_ENTRIES];
    int unsigned            fill_count = 0;
    int unsigned            walk_pos   = 0;
    logic [TOTAL_BITS-1:0]  first_sum  = '0;
    logic [TOTAL_BITS-1:0]  second_sum = '0;
    logic [TOTAL_BITS-1:0]  min_sum    = '0;
    logic [KEY_BITS-1:0]    prev_key   = '0;
    bit                     entry_seen = 1'b0;
    t_err_code              err_state  = ERR_NONE;

    function automatic logic [TOTAL_BITS-1:0] sat_add(logic [TOTAL_BITS-1:0] a,
                                                      logic [WEIGHT_BITS-1:0] b);
        logic [TOTAL_BITS:0] s;
        s = (TOTAL_BITS+1)'(a) + (TOTAL_BITS+1)'(b);
        return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
    endfunction

    // First error of a pair sticks
    function automatic void note_error(t_err_code code);
        if (err_state == ERR_NONE) err_state = code;
    endfunction

    function automatic void clear_pair_state();
        fill_count = 0;
        walk_pos   = 0;
        first_sum  = '0;
        second_sum = '0;
        min_sum    = '0;
        prev_key   = '0;
        entry_seen = 1'b0;
        err_state  = ERR_NONE;
    endfunction

    // Applies one accepted entry; a merge entry with end_of_vector yields a result.
    function automatic void predict_entry(t_entry e);
        bit                     in_order;
        logic [WEIGHT_BITS-1:0] mw;
        logic [TOTAL_BITS:0]    uni;
        logic [TOTAL_BITS-1:0]  com;
        logic [63:0]            quo;
        t_result                r;
        in_order = !entry_seen || (e.key > prev_key);
        if (!in_order) begin
            note_error(ERR_ORDER);   // dropped; only its end mark below still acts
        end else begin
            prev_key   = e.key;
            entry_seen = 1'b1;
            if (e.cmd == CMD_STORE) begin
                if (fill_count < MAX_ENTRIES) begin
                    stored_key[fill_count] = e.key;
                    stored_wt[fill_count]  = e.weight;
                    fill_count++;
                    first_sum = sat_add(first_sum, e.weight);
                end else begin
                    note_error(ERR_OVERFLOW);
                end
            end else begin
                // walk forward past smaller stored keys, then take a match if any
                while (walk_pos < fill_count && stored_key[walk_pos] < e.key) walk_pos++;
                if (walk_pos < fill_count && stored_key[walk_pos] == e.key) begin
                    mw = (stored_wt[walk_pos] < e.weight) ? stored_wt[walk_pos] : e.weight;
                    min_sum = sat_add(min_sum, mw);
                    walk_pos++;
                end
                second_sum = sat_add(second_sum, e.weight);
            end
        end
        if (e.eov) begin
            if (e.cmd == CMD_STORE) begin
                // second vector's order is checked on its own
                entry_seen = 1'b0;
                prev_key   = '0;
            end else begin
                com = min_sum;
                uni = {1'b0, first_sum} + {1'b0, second_sum};
                uni = (uni >= {1'b0, com}) ? uni - {1'b0, com} : '0;
                if ({1'b0, com} > uni) com = uni[TOTAL_BITS-1:0];
                r.undefined = (uni == 0);
                if (uni == 0) begin
                    r.ratio = '0;
                end else begin
                    quo = ({32'd0, com} << FRACTION_BITS) / {31'd0, uni};
                    r.ratio = quo[SIM_BITS-1:0];
                end
                r.common_sum = (com > COMMON_MAX) ? COMMON_MAX : com[COMMON_BITS-1:0];
                r.union_sum  = (uni > UNION_MAX) ? UNION_MAX : uni[UNION_BITS-1:0];
                r.err        = err_state;
                expected_results = {expected_results, r};
                clear_pair_state();
            end
        end
    endfunction

    //------------------------------------------------------------------
    // Driver: offers pending entries, predicts each one on its transfer.
    // Valid only drops or moves on after a transfer (or while empty).
    //------------------------------------------------------------------
    t_entry next_entry;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_entry('{i_cmd, i_key, i_weight, i_end_of_vector});
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_entries.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    next_entry       = pending_entries.pop_front();
                    i_cmd           <= next_entry.cmd;
                    i_key           <= next_entry.key;
                    i_weight        <= next_entry.weight;
                    i_end_of_vector <= next_entry.eov;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver ready: random idling, plus a long hold-off on request
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_taken != hold_req) begin
            hold_taken  <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    //------------------------------------------------------------------
    // Monitor: each result transfer against the oldest prediction
    //------------------------------------------------------------------
    t_result want;

    function automatic void check_field(string name, logic [31:0] exp_val,
                                        logic [31:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result transfer with none expected, actual %0d/%0d/%0d",
                             $time, o_common_weight_sum, o_union_weight_sum, o_similarity);
            end else begin
                want = expected_results.pop_front();
                check_field("common_weight_sum", want.common_sum, o_common_weight_sum);
                check_field("union_weight_sum", want.union_sum, o_union_weight_sum);
                check_field("similarity", want.ratio, o_similarity);
                check_field("undefined_ratio", want.undefined, o_undefined_ratio);
                check_field("error_code", want.err, o_error_code);
            end
        end
    end

    // Watchdog on cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("weighted_jaccard_sparse_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers (all called on the falling edge)
    //------------------------------------------------------------------
    task automatic queue_entry(bit cmd, logic [KEY_BITS-1:0] key,
                               logic [WEIGHT_BITS-1:0] wt, bit eov);
        t_entry e;
        e = '{cmd, key, wt, eov};
        pending_entries = {pending_entries, e};
        queued_items++;
    endtask

    function automatic logic [WEIGHT_BITS-1:0] rand_weight(int mode);
        int unsigned r;
        r = $urandom_range(9);
        case (mode)
            1:       return '1;
            2:       return '0;
            3:       return WEIGHT_BITS'($urandom_range(3));
            default: return (r == 0) ? '0 : (r == 1) ? '1 : WEIGHT_BITS'($urandom);
        endcase
    endfunction

    // Real entry, sometimes preceded by a stray one: a repeated key, the other
    // vector's cmd, or a fully random entry.
    task automatic queue_noisy(bit cmd, logic [KEY_BITS-1:0] key,
                               logic [WEIGHT_BITS-1:0] wt, bit eov, int noise_pct);
        if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
                0:       queue_entry(cmd, key, rand_weight(0), 1'b0);
                1:       queue_entry(!cmd, key, rand_weight(0), 1'b0);
                default: queue_entry($urandom_range(1), $urandom, rand_weight(0), 1'b0);
            endcase
        end
        queue_entry(cmd, key, wt, eov);
    endtask

    // One pair of vectors over a shared ascending key walk; each key lands in
    // the first vector, the second, or both.
    task automatic queue_vector_pair(int unsigned n_keys, int unsigned gap_max,
                                     int unsigned a_only_pct, int unsigned both_pct,
                                     int wt_mode, int noise_pct);
        logic [63:0]         k;
        logic [63:0]         span;
        logic [KEY_BITS-1:0] a_keys[$];
        logic [KEY_BITS-1:0] b_keys[$];
        int unsigned         r;
        bit                  mark_a;
        span = 64'(n_keys) * 64'(gap_max);
        case ($urandom_range(3))
            0:       k = 0;
            1:       k = $urandom_range(255);
            2:       k = $urandom;
            default: k = (span >= 64'h1_0000_0000) ? 0 : 64'h1_0000_0000 - span;
        endcase
        for (int unsigned i = 0; i < n_keys && k <= 64'hFFFF_FFFF; i++) begin
            r = $urandom_range(99);
            if (r < a_only_pct + both_pct) a_keys = {a_keys, k[KEY_BITS-1:0]};
            if (r >= a_only_pct) b_keys = {b_keys, k[KEY_BITS-1:0]};
            k = k + $urandom_range(1, gap_max);
        end
        if (b_keys.size() == 0) b_keys = {b_keys, a_keys[a_keys.size()-1]};
        // now and then the first vector goes without its end mark
        mark_a = ($urandom_range(19) != 0);
        foreach (a_keys[i])
            queue_noisy(CMD_STORE, a_keys[i], rand_weight(wt_mode),
                        mark_a && (i == a_keys.size() - 1), noise_pct);
        foreach (b_keys[i])
            queue_noisy(CMD_MERGE, b_keys[i], rand_weight(wt_mode),
                        i == b_keys.size() - 1, noise_pct);
    endtask

    // Sender pause: everything offered, taken and answered, then a tail
    task automatic wait_idle(int unsigned tail);
        while (pending_entries.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    //------------------------------------------------------------------
    // Stimulus sequence
    //------------------------------------------------------------------
    initial begin : stimulus
        int unsigned random_start;
        int unsigned gap;
        int unsigned a_pct;
        int unsigned pairs;
        int unsigned r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty union, extremes of key and weight, repeated keys in
        // both vectors, missing end mark on the first vector, an entry for the
        // store arriving mid-merge, disjoint and zero-weight vectors.
        queue_entry(CMD_MERGE, '0, '0, 1'b1);
        queue_entry(CMD_STORE, '0, '1, 1'b0);
        queue_entry(CMD_STORE, '1, '1, 1'b1);
        queue_entry(CMD_MERGE, '0, '1, 1'b0);
        queue_entry(CMD_MERGE, '1, '1, 1'b1);
        queue_entry(CMD_STORE, 32'd5, 16'd10, 1'b1);
        queue_entry(CMD_MERGE, 32'd5, 16'd3, 1'b0);
        queue_entry(CMD_MERGE, 32'd5, 16'd7, 1'b0);
        queue_entry(CMD_MERGE, 32'd9, 16'd0, 1'b1);
        queue_entry(CMD_STORE, 32'd100, 16'd7, 1'b0);
        queue_entry(CMD_STORE, 32'd100, 16'd1, 1'b0);
        queue_entry(CMD_STORE, 32'd200, 16'd8, 1'b0);
        queue_entry(CMD_MERGE, 32'd150, 16'd2, 1'b0);
        queue_entry(CMD_MERGE, 32'd300, 16'd8, 1'b1);
        queue_entry(CMD_STORE, 32'd1, 16'd4, 1'b1);
        queue_entry(CMD_MERGE, 32'd3, 16'd2, 1'b0);
        queue_entry(CMD_STORE, 32'd4, 16'd9, 1'b0);
        queue_entry(CMD_MERGE, 32'd4, 16'd5, 1'b1);
        queue_entry(CMD_STORE, 32'd2, 16'd1, 1'b1);
        queue_entry(CMD_MERGE, 32'd3, 16'd1, 1'b1);
        queue_entry(CMD_STORE, 32'd7, 16'd0, 1'b1);
        queue_entry(CMD_MERGE, 32'd7, 16'd0, 1'b0);
        queue_entry(CMD_MERGE, 32'd8, 16'd0, 1'b1);
        wait_idle(40);

        // Receiver holds off while short pairs keep coming: the result
        // register fills and the entry channel must back up.
        hold_req = hold_req + 1;
        repeat (12) queue_entry(CMD_MERGE, $urandom, rand_weight(0), 1'b1);
        wait_idle(40);

        // Full store and overflow. The overflowing pair also has an order
        // error later on; the overflow code must be the one reported.
        for (int i = 0; i < 258; i++)
            queue_entry(CMD_STORE, 32'(i), rand_weight(0), i == 257);
        queue_entry(CMD_MERGE, 32'd3, 16'd1, 1'b0);
        queue_entry(CMD_MERGE, 32'd2, 16'd1, 1'b1);
        for (int i = 0; i < 32; i++)
            queue_entry(CMD_STORE, 32'(i * 3), rand_weight(0), i == 31);
        for (int i = 0; i < 32; i++)
            queue_entry(CMD_MERGE, 32'(i * 3 + i % 2), rand_weight(0), i == 31);
        wait_idle(40);

        // Random pairs: mostly clean, some with stray entries, some bare noise
        random_start = queued_items;
        pairs = 0;
        while (queued_items - random_start < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            case ($urandom_range(2))
                0:       gap = 1;
                1:       gap = 16;
                default: gap = 32'h0800_0000;
            endcase
            a_pct = $urandom_range(60);
            if (r < 70) begin
                queue_vector_pair($urandom_range(1, 12), gap, a_pct,
                                  $urandom_range(100 - a_pct), $urandom_range(3), 0);
            end else if (r < 90) begin
                queue_vector_pair($urandom_range(1, 12), gap, a_pct,
                                  $urandom_range(100 - a_pct), 0, 15);
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_entry($urandom_range(1), $urandom, rand_weight(0),
                                $urandom_range(9) == 0);
            end
            pairs++;
            if (pairs % 25 == 0) wait_idle(40);
            else repeat ($urandom_range(8)) @(negedge i_clk);
        end
        wait_idle(40);

        // No idling on either side. A full store of heavy entries against a
        // disjoint heavy second vector: the union output saturates.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            queue_entry(CMD_STORE, 32'(i * 2), '1, i == MAX_ENTRIES - 1);
        for (int i = 0; i < MAX_ENTRIES + 1; i++)
            queue_entry(CMD_MERGE, 32'(i * 2 + 1), '1, i == MAX_ENTRIES);
        wait_idle(40);
        in_idle_pct  = 38;
        out_idle_pct = 38;

        // Everything answered; allow the walk of any trailing entry to finish
        wait_idle(300);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("weighted_jaccard_sparse_unit test passed");
        end else begin
            $display("weighted_jaccard_sparse_unit test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/wjs_pkg.sv
rtl/core/wjs_ram.sv
rtl/core/wjs_datapath.sv
rtl/core/wjs_controller.sv
rtl/core/weighted_jaccard_sparse_unit.sv
rtl/core/wjs_checker.sv
tb/testbench.sv
